// ----- rtl/cafs_pkg.sv -----
// ----------------------------------------------------------------------------
// cafs_pkg
// Shared constants, types and helpers of the cave smoothing filter.
// ----------------------------------------------------------------------------
package cafs_pkg;

    localparam int MAX_COLS = 1024;
    localparam int MAX_ROWS = 1024;

    // Store index and position counter widths
    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int ROW_W  = $clog2(MAX_ROWS);
    // Widths that hold the effective size itself
    localparam int COLS_W = $clog2(MAX_COLS + 1);
    localparam int ROWS_W = $clog2(MAX_ROWS + 1);

    // Register and field widths
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam int THR_W     = 4;
    localparam int OUT_W     = 10;
    localparam int CNT_W     = 4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAP_COLS       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_ROWS       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WALL_THRESHOLD = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ENCLOSE_BORDER = 2'd3;

    // Register reset values
    localparam logic [CFG_W-1:0] MAP_COLS_RST       = 11'd1001;
    localparam logic [CFG_W-1:0] MAP_ROWS_RST       = 11'd1001;
    localparam logic [THR_W-1:0] WALL_THRESHOLD_RST = 4'd4;
    localparam logic             ENCLOSE_BORDER_RST = 1'b0;

    // Input item kinds
    localparam logic FUNC_CELL  = 1'b0;
    localparam logic FUNC_DRAIN = 1'b1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QP_W        = $clog2(QUEUE_DEPTH);
    localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

    // One classified item handed from the front to the back
    typedef struct packed {
        logic             store_wr;  // map cell: update line stores
        logic [COL_W-1:0] addr;      // line store column
        logic             bot;       // new bottom-row bit of the window
        logic             emit;      // produces a result
        logic [2:0]       row_mask;  // window rows inside the interior
        logic [2:0]       col_mask;  // window columns inside the interior
        logic             border;
        logic [OUT_W-1:0] row;
        logic [OUT_W-1:0] col;
        logic             last;
    } cafs_item_t;

    function automatic logic [COLS_W-1:0] cafs_eff_cols(input logic [CFG_W-1:0] v);
        logic [COLS_W-1:0] r;
        if (int'(v) < 3)
            r = COLS_W'(3);
        else if (int'(v) > MAX_COLS)
            r = COLS_W'(MAX_COLS);
        else
            r = COLS_W'(v);
        return r;
    endfunction

    function automatic logic [ROWS_W-1:0] cafs_eff_rows(input logic [CFG_W-1:0] v);
        logic [ROWS_W-1:0] r;
        if (int'(v) < 3)
            r = ROWS_W'(3);
        else if (int'(v) > MAX_ROWS)
            r = ROWS_W'(MAX_ROWS);
        else
            r = ROWS_W'(v);
        return r;
    endfunction

endpackage

// ----- rtl/cave_automaton_smoothing_filter.sv -----
// ----------------------------------------------------------------------------
// cave_automaton_smoothing_filter
// One 3x3 majority smoothing pass over a binary wall map streamed in raster
// order.
//
// Input channel (in_valid/in_ready): func selects a map cell (cell_in, 1 is
// wall) or a drain beat. Output channel (out_valid/out_ready): one smoothed
// cell with its row and column; frame_end marks the last cell of the map.
// Results lag the input by one row plus one cell: the first map_cols+1 cells
// of a map give no result, and map_cols+1 drain beats after the last cell
// flush the rest. Drain beats with nothing pending are dropped.
// Throughput is one beat per cycle while the queue has room. A two-entry
// queue separates the input classifier from the line store and window
// datapath, and the output register lets the input keep flowing while a
// result waits. When the receiver stalls, the back end holds and the queue
// fills; in_ready drops once it is full. Configuration (cfg_valid/cfg_ready,
// always ready) must be written only while idle; the block itself does not
// enforce this. Reset clears all position counters and restores the
// register defaults; line store contents are not cleared.
// ----------------------------------------------------------------------------
module cave_automaton_smoothing_filter import cafs_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 func,
    input  logic                 cell_in,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 cell_out,
    output logic [OUT_W-1:0]     out_row,
    output logic [OUT_W-1:0]     out_col,
    output logic                 frame_end
);

    logic [CFG_W-1:0] map_cols_reg, map_cols_next;
    logic [CFG_W-1:0] map_rows_reg, map_rows_next;
    logic [THR_W-1:0] wall_threshold_reg, wall_threshold_next;
    logic             enclose_border_reg, enclose_border_next;

    logic             q_push;
    logic             q_full;
    logic             q_pop;
    logic             q_valid;
    cafs_item_t       push_item;
    cafs_item_t       pop_item;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        map_cols_next       = map_cols_reg;
        map_rows_next       = map_rows_reg;
        wall_threshold_next = wall_threshold_reg;
        enclose_border_next = enclose_border_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_MAP_COLS:       map_cols_next       = cfg_data;
                REG_MAP_ROWS:       map_rows_next       = cfg_data;
                REG_WALL_THRESHOLD: wall_threshold_next = cfg_data[THR_W-1:0];
                REG_ENCLOSE_BORDER: enclose_border_next = cfg_data[0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_cols_reg       <= MAP_COLS_RST;
            map_rows_reg       <= MAP_ROWS_RST;
            wall_threshold_reg <= WALL_THRESHOLD_RST;
            enclose_border_reg <= ENCLOSE_BORDER_RST;
        end
        else
        begin
            map_cols_reg       <= map_cols_next;
            map_rows_reg       <= map_rows_next;
            wall_threshold_reg <= wall_threshold_next;
            enclose_border_reg <= enclose_border_next;
        end
    end

    cafs_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .func     (func),
        .cell_in  (cell_in),
        .map_cols (map_cols_reg),
        .map_rows (map_rows_reg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    cafs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_item  (pop_item)
    );

    cafs_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_item         (pop_item),
        .q_pop          (q_pop),
        .wall_threshold (wall_threshold_reg),
        .enclose_border (enclose_border_reg),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .cell_out       (cell_out),
        .out_row        (out_row),
        .out_col        (out_col),
        .frame_end      (frame_end)
    );

    // Every map cell must reach the back end
    a_cell_enqueued: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && func == FUNC_CELL) |-> q_push)
        else $error("map cell beat not enqueued");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> (!q_full || q_pop))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("queue pop while empty");

    // The frame-end cell sits in the last column of the map
    a_frame_end_col: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_end) |->
            (COLS_W'(out_col) + COLS_W'(1) == cafs_eff_cols(map_cols_reg)))
        else $error("frame end outside the last column");

endmodule

// ----- rtl/cafs_ram.sv -----
// ----------------------------------------------------------------------------
// cafs_ram
// Generic single-write, single-read RAM with registered, enabled read data.
// ----------------------------------------------------------------------------
module cafs_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/cafs_front.sv -----
// ----------------------------------------------------------------------------
// cafs_front
// Input side: tracks raster and emit positions, classifies each beat and
// builds the window masks and output coordinates for the back end.
// ----------------------------------------------------------------------------
module cafs_front import cafs_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             func,
    input  logic             cell_in,
    input  logic [CFG_W-1:0] map_cols,
    input  logic [CFG_W-1:0] map_rows,
    input  logic             q_full,
    output logic             q_push,
    output cafs_item_t       q_item
);

    localparam int CX_W = COLS_W + 1;
    localparam int RX_W = ROWS_W + 1;

    logic [COL_W-1:0]  in_col_reg, in_col_next;
    logic [ROW_W-1:0]  in_row_reg, in_row_next;
    logic [COL_W-1:0]  emit_col_reg, emit_col_next;
    logic [ROW_W-1:0]  emit_row_reg, emit_row_next;
    logic              tail_reg, tail_next;

    logic [COLS_W-1:0] cols;
    logic [ROWS_W-1:0] rows;
    logic              accept;
    logic              is_drain;
    logic              restart;
    logic              map_emit;
    logic              last;
    logic [COL_W-1:0]  ec_base;
    logic [ROW_W-1:0]  er_base;
    logic [CX_W-1:0]   ec_x, ec_inc, ic_inc;
    logic [RX_W-1:0]   er_x, er_inc, ir_inc;
    logic              ec_wrap, er_wrap, ic_wrap, ir_wrap;
    logic [COL_W-1:0]  drain_addr;
    logic [COL_W-1:0]  emit_col_adv;
    logic [ROW_W-1:0]  emit_row_adv;

    always_comb
    begin
        cols     = cafs_eff_cols(map_cols);
        rows     = cafs_eff_rows(map_rows);
        in_ready = !q_full;
        accept   = in_valid && in_ready;
        is_drain = (func == FUNC_DRAIN);
        restart  = !is_drain && (in_row_reg == '0) && (in_col_reg == '0);

        // A new map restarts the emit position before anything else
        er_base = restart ? '0 : emit_row_reg;
        ec_base = restart ? '0 : emit_col_reg;

        map_emit = (in_row_reg >= ROW_W'(2))
                   || ((in_row_reg == ROW_W'(1)) && (in_col_reg != '0));

        ec_x    = CX_W'(ec_base);
        ec_inc  = ec_x + CX_W'(1);
        ec_wrap = ec_inc >= CX_W'(cols);
        er_x    = RX_W'(er_base);
        er_inc  = er_x + RX_W'(1);
        er_wrap = er_inc >= RX_W'(rows);
        last    = ec_wrap && er_wrap;

        ic_inc  = CX_W'(in_col_reg) + CX_W'(1);
        ic_wrap = ic_inc >= CX_W'(cols);
        ir_inc  = RX_W'(in_row_reg) + RX_W'(1);
        ir_wrap = ir_inc >= RX_W'(rows);

        // Drain reads the column one ahead of the emit position
        drain_addr   = ec_wrap ? '0 : COL_W'(ec_inc);
        emit_col_adv = ec_wrap ? '0 : COL_W'(ec_inc);
        emit_row_adv = ec_wrap ? (er_wrap ? '0 : ROW_W'(er_inc)) : er_base;

        q_item.store_wr    = !is_drain;
        q_item.addr        = is_drain ? drain_addr : in_col_reg;
        q_item.bot         = is_drain ? 1'b0 : cell_in;
        q_item.emit        = is_drain ? tail_reg : map_emit;
        q_item.row_mask[0] = (er_x >= RX_W'(2)) && (er_inc <= RX_W'(rows));
        q_item.row_mask[1] = (er_x >= RX_W'(1)) && (er_x + RX_W'(2) <= RX_W'(rows));
        q_item.row_mask[2] = (er_x + RX_W'(3) <= RX_W'(rows));
        q_item.col_mask[0] = (ec_x >= CX_W'(2)) && (ec_inc <= CX_W'(cols));
        q_item.col_mask[1] = (ec_x >= CX_W'(1)) && (ec_x + CX_W'(2) <= CX_W'(cols));
        q_item.col_mask[2] = (ec_x + CX_W'(3) <= CX_W'(cols));
        q_item.border      = (er_x == '0) || (ec_x == '0) || er_wrap || ec_wrap;
        q_item.row         = OUT_W'(er_base);
        q_item.col         = OUT_W'(ec_base);
        q_item.last        = last;

        // Drop drain beats that arrive with nothing left to flush
        q_push = accept && (!is_drain || tail_reg);

        in_col_next   = in_col_reg;
        in_row_next   = in_row_reg;
        emit_col_next = emit_col_reg;
        emit_row_next = emit_row_reg;
        tail_next     = tail_reg;

        if (accept && !is_drain)
        begin
            in_col_next = ic_wrap ? '0 : COL_W'(ic_inc);
            if (ic_wrap)
            begin
                in_row_next = ir_wrap ? '0 : ROW_W'(ir_inc);
            end
            if (restart)
            begin
                tail_next = 1'b0;
            end
            if (ic_wrap && ir_wrap)
            begin
                tail_next = 1'b1;
            end
            if (map_emit)
            begin
                emit_col_next = emit_col_adv;
                emit_row_next = emit_row_adv;
            end
            else
            begin
                emit_col_next = ec_base;
                emit_row_next = er_base;
            end
        end
        else if (accept && tail_reg)
        begin
            emit_col_next = emit_col_adv;
            emit_row_next = emit_row_adv;
            if (last)
            begin
                tail_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            emit_col_reg <= '0;
            emit_row_reg <= '0;
            tail_reg     <= 1'b0;
        end
        else
        begin
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            emit_col_reg <= emit_col_next;
            emit_row_reg <= emit_row_next;
            tail_reg     <= tail_next;
        end
    end

endmodule

// ----- rtl/cafs_queue.sv -----
// ----------------------------------------------------------------------------
// cafs_queue
// Short FIFO of classified items between the front and the back end.
// ----------------------------------------------------------------------------
module cafs_queue import cafs_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  cafs_item_t push_item,
    output logic       full,
    input  logic       pop,
    output logic       valid,
    output cafs_item_t pop_item
);

    cafs_item_t       entries_reg [QUEUE_DEPTH];
    logic [QP_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QP_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QC_W-1:0]  count_reg, count_next;

    always_comb
    begin
        full     = (count_reg == QC_W'(QUEUE_DEPTH));
        valid    = (count_reg != '0);
        pop_item = entries_reg[rd_ptr_reg];

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QP_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + QP_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QP_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + QP_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + QC_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QC_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- rtl/cafs_back.sv -----
// ----------------------------------------------------------------------------
// cafs_back
// Execution side: line store access, 3x3 window shift, masked wall count,
// threshold decision and the output register.
// ----------------------------------------------------------------------------
module cafs_back import cafs_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  cafs_item_t       q_item,
    output logic             q_pop,
    input  logic [THR_W-1:0] wall_threshold,
    input  logic             enclose_border,
    output logic             out_valid,
    input  logic             out_ready,
    output logic             cell_out,
    output logic [OUT_W-1:0] out_row,
    output logic [OUT_W-1:0] out_col,
    output logic             frame_end
);

    logic             b1_valid_reg, b1_valid_next;
    cafs_item_t       b1_item_reg;
    logic [8:0]       window_reg, window_next;
    logic             out_valid_reg, out_valid_next;
    logic             cell_out_reg;
    logic [OUT_W-1:0] out_row_reg;
    logic [OUT_W-1:0] out_col_reg;
    logic             frame_end_reg;

    logic [1:0]       store_rdata;  // [1] upper row, [0] middle row
    logic             out_free;
    logic             b1_go;
    logic             b1_load;
    logic             load_out;
    logic [8:0]       mask;
    logic [CNT_W-1:0] wall_count;
    logic             wall;

    // Upper and middle line stores share one address, so keep them in one RAM
    cafs_ram #(
        .WIDTH (2),
        .DEPTH (MAX_COLS)
    ) u_line_store (
        .clk   (clk),
        .we    (b1_go && b1_item_reg.store_wr),
        .waddr (b1_item_reg.addr),
        .wdata ({store_rdata[0], b1_item_reg.bot}),
        .re    (q_pop),
        .raddr (q_item.addr),
        .rdata (store_rdata)
    );

    always_comb
    begin
        out_free = !out_valid_reg || out_ready;
        // Items that make no result still retire to shift the window
        b1_go    = b1_valid_reg && (!b1_item_reg.emit || out_free);
        b1_load  = !b1_valid_reg || b1_go;
        q_pop    = q_valid && b1_load;
        load_out = b1_go && b1_item_reg.emit;

        b1_valid_next = b1_load ? q_valid : b1_valid_reg;

        window_next = window_reg;
        if (b1_go)
        begin
            window_next = {b1_item_reg.bot, store_rdata[0], store_rdata[1], window_reg[8:3]};
        end

        // Bit dc*3+dr of the window: dc column (oldest first), dr row (top first)
        for (int dc = 0; dc < 3; dc++)
        begin
            for (int dr = 0; dr < 3; dr++)
            begin
                mask[dc*3 + dr] = b1_item_reg.col_mask[dc] && b1_item_reg.row_mask[dr];
            end
        end

        wall_count = '0;
        for (int i = 0; i < 9; i++)
        begin
            wall_count = wall_count + CNT_W'(window_next[i] && mask[i]);
        end
        wall = (wall_count > wall_threshold) || (enclose_border && b1_item_reg.border);

        if (load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            b1_item_reg <= q_item;
        end
        if (load_out)
        begin
            cell_out_reg  <= wall;
            out_row_reg   <= b1_item_reg.row;
            out_col_reg   <= b1_item_reg.col;
            frame_end_reg <= b1_item_reg.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg  <= 1'b0;
            window_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            b1_valid_reg  <= b1_valid_next;
            window_reg    <= window_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign cell_out  = cell_out_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign frame_end = frame_end_reg;

endmodule

// ----- tb/cafs_checker.sv -----
// ----------------------------------------------------------------------------
// cafs_checker
// Watches the register, cell and result channels of the cave smoothing
// filter. It keeps its own copy of the line stores, the 3x3 window and the
// raster counters, works out each smoothed cell as beats are taken, and
// compares every result beat field by field with the oldest one due.
// ----------------------------------------------------------------------------
module cafs_checker import cafs_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic                 func,
    input  logic                 cell_in,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic                 cell_out,
    input  logic [OUT_W-1:0]     out_row,
    input  logic [OUT_W-1:0]     out_col,
    input  logic                 frame_end,
    output int                   results_due,
    output int                   mismatches,
    output int                   cells_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic             wall;
        logic [OUT_W-1:0] row;
        logic [OUT_W-1:0] col;
        logic             last;
    } cave_cell_t;

    cave_cell_t smoothed_due[$];
    cave_cell_t want;

    // Register copies
    logic [CFG_W-1:0] cols_reg;
    logic [CFG_W-1:0] rows_reg;
    logic [THR_W-1:0] thr_reg;
    logic             enc_reg;

    // Line stores, window and raster position
    bit       upper_line [MAX_COLS];
    bit       middle_line [MAX_COLS];
    bit [8:0] window;
    int       in_row, in_col, emit_row, emit_col;
    bit       tail_open;

    int fault_tally;
    int checked_tally;

    initial begin
        fault_tally   = 0;
        checked_tally = 0;
    end

    function automatic int size_used(input int raw, input int cap);
        if (raw < 3)
            return 3;
        if (raw > cap)
            return cap;
        return raw;
    endfunction

    // bit 8 bottom, 7 middle, 6 top of the newest column; oldest column drops
    function automatic void shift_window(input bit top, input bit mid, input bit bot);
        window = {bot, mid, top, window[8:3]};
    endfunction

    function automatic cave_cell_t emit_cell();
        cave_cell_t r;
        int ncol, nrow, cnt, wr, wc;
        bit border;
        ncol = size_used(int'(cols_reg), MAX_COLS);
        nrow = size_used(int'(rows_reg), MAX_ROWS);
        cnt = 0;
        for (int dc = 0; dc < 3; dc++) begin
            for (int dr = 0; dr < 3; dr++) begin
                wr = emit_row + dr - 1;
                wc = emit_col + dc - 1;
                // border cells never count
                if (wr >= 1 && wr <= nrow - 2 && wc >= 1 && wc <= ncol - 2)
                    cnt += window[dc * 3 + dr];
            end
        end
        border = emit_row == 0 || emit_col == 0 || emit_row >= nrow - 1
                 || emit_col >= ncol - 1;
        r.wall = (cnt > int'(thr_reg)) || (enc_reg && border);
        r.row  = OUT_W'(emit_row);
        r.col  = OUT_W'(emit_col);
        r.last = 1'b0;
        emit_col++;
        if (emit_col >= ncol) begin
            emit_col = 0;
            emit_row++;
            if (emit_row >= nrow) begin
                emit_row = 0;
                r.last = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic void take_register(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_W-1:0] data);
        case (idx)
            REG_MAP_COLS:       cols_reg = data;
            REG_MAP_ROWS:       rows_reg = data;
            REG_WALL_THRESHOLD: thr_reg  = data[THR_W-1:0];
            REG_ENCLOSE_BORDER: enc_reg  = data[0];
            default: ;
        endcase
    endfunction

    function automatic void smooth_beat(input logic kind, input logic cell_bit);
        int ncol, nrow, idx;
        cave_cell_t r;
        ncol = size_used(int'(cols_reg), MAX_COLS);
        nrow = size_used(int'(rows_reg), MAX_ROWS);
        if (kind == FUNC_DRAIN) begin
            // drop drain beats with nothing left to flush
            if (tail_open) begin
                idx = emit_col + 1;
                if (idx >= ncol)
                    idx = 0;
                idx = idx % MAX_COLS;
                shift_window(upper_line[idx], middle_line[idx], 1'b0);
                r = emit_cell();
                if (r.last)
                    tail_open = 1'b0;
                smoothed_due.push_back(r);
            end
        end else begin
            // first cell of a map drops whatever is left of the previous one
            if (in_row == 0 && in_col == 0) begin
                emit_row  = 0;
                emit_col  = 0;
                tail_open = 1'b0;
            end
            idx = in_col % MAX_COLS;
            shift_window(upper_line[idx], middle_line[idx], cell_bit);
            upper_line[idx]  = middle_line[idx];
            middle_line[idx] = cell_bit;
            if (in_row >= 2 || (in_row == 1 && in_col >= 1))
                smoothed_due.push_back(emit_cell());
            in_col++;
            if (in_col >= ncol) begin
                in_col = 0;
                in_row++;
                if (in_row >= nrow) begin
                    in_row    = 0;
                    tail_open = 1'b1;
                end
            end
        end
    endfunction

    task automatic report_fault(input string msg);
        if (fault_tally < 20)
            $display("[%0t] mismatch: %s", $time, msg);
        fault_tally++;
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            cols_reg  = MAP_COLS_RST;
            rows_reg  = MAP_ROWS_RST;
            thr_reg   = WALL_THRESHOLD_RST;
            enc_reg   = ENCLOSE_BORDER_RST;
            window    = '0;
            in_row    = 0;
            in_col    = 0;
            emit_row  = 0;
            emit_col  = 0;
            tail_open = 1'b0;
            smoothed_due.delete();
        end else begin
            if (out_valid && out_ready) begin
                if (smoothed_due.size() == 0) begin
                    report_fault($sformatf("result beat at row %0d col %0d with none due",
                                           out_row, out_col));
                end else begin
                    want = smoothed_due.pop_front();
                    checked_tally++;
                    if (cell_out !== want.wall)
                        report_fault($sformatf("cell_out %b, want %b at row %0d col %0d",
                                               cell_out, want.wall, want.row, want.col));
                    if (out_row !== want.row)
                        report_fault($sformatf("out_row %0d, want %0d", out_row, want.row));
                    if (out_col !== want.col)
                        report_fault($sformatf("out_col %0d, want %0d", out_col, want.col));
                    if (frame_end !== want.last)
                        report_fault($sformatf("frame_end %b, want %b at row %0d col %0d",
                                               frame_end, want.last, want.row, want.col));
                end
            end
            if (cfg_valid && cfg_ready)
                take_register(cfg_index, cfg_data);
            if (in_valid && in_ready)
                smooth_beat(func, cell_in);
        end
        results_due   <= smoothed_due.size();
        mismatches    <= fault_tally;
        cells_checked <= checked_tally;
    end

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the cave smoothing filter. Writes register
// settings while idle, streams wall maps in bursts with drain beats behind
// them, stalls the result side on a shifting pattern with one long hold-off,
// and leaves prediction and comparison to the checker.
// ----------------------------------------------------------------------------
module testbench import cafs_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int SETTLE       = 12;
    localparam int RANDOM_ITEMS = 950;
    localparam int NOISE_PCT    = 2;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic                 func;
    logic                 cell_in;
    logic                 out_valid;
    logic                 out_ready;
    logic                 cell_out;
    logic [OUT_W-1:0]     out_row;
    logic [OUT_W-1:0]     out_col;
    logic                 frame_end;
    int                   results_due;
    int                   mismatches;
    int                   cells_checked;

    int cycle_count;
    int burst_left;
    int beats_taken;
    int useful_beats;
    int cells_sent;
    int drains_sent;
    int maps_run;
    int settings_run;

    cave_automaton_smoothing_filter u_dut (.*);

    cafs_checker u_chk (.*);

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("run stopped at the cycle limit with %0d results still due", results_due);
        $display("testbench failed");
        $finish;
    end

    // Result side: shifting stall patterns, one long hold-off to back up the input
    initial begin
        int mode;
        int span;
        bit held;
        out_ready = 1'b0;
        held = 1'b0;
        forever
        begin
            if (!held && beats_taken >= 200 && in_valid) begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (400) @(posedge clk);
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 120);
            repeat (span)
            begin
                case (mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= 1'($urandom_range(0, 1));
                    2: out_ready <= $urandom_range(0, 9) < 8;
                    default: out_ready <= $urandom_range(0, 3) == 0;
                endcase
                @(posedge clk);
            end
        end
    end

    task automatic push_beat(input logic kind, input logic cell_bit);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        func     <= kind;
        cell_in  <= cell_bit;
        do @(posedge clk); while (!in_ready);
        burst_left--;
        beats_taken++;
        if (kind == FUNC_DRAIN)
            drains_sent++;
        else
            cells_sent++;
    endtask

    // One full map, the odd stray drain mixed in, then the given drain beats
    task automatic run_map(input int ncol, input int nrow, input int fill_pct,
                           input int drains);
        for (int i = 0; i < ncol * nrow; i++) begin
            if ($urandom_range(0, 99) < NOISE_PCT)
                push_beat(FUNC_DRAIN, 1'($urandom_range(0, 1)));
            push_beat(FUNC_CELL, $urandom_range(0, 99) < fill_pct);
        end
        repeat (drains) push_beat(FUNC_DRAIN, 1'($urandom_range(0, 1)));
        useful_beats += ncol * nrow + ((drains > ncol + 1) ? ncol + 1 : drains);
        maps_run++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // Spare upper data bits on the narrow registers carry noise
    task automatic apply_settings(input int cols_raw, input int rows_raw, input int thr,
                                  input int enc);
        in_valid <= 1'b0;
        write_reg(REG_MAP_COLS, CFG_W'(cols_raw));
        write_reg(REG_MAP_ROWS, CFG_W'(rows_raw));
        write_reg(REG_WALL_THRESHOLD,
                  {(CFG_W - THR_W)'($urandom_range(0, 127)), THR_W'(thr)});
        write_reg(REG_ENCLOSE_BORDER, {(CFG_W - 1)'($urandom), 1'(enc)});
        cfg_valid <= 1'b0;
        settings_run++;
    endtask

    // Hold the input until every result is in, then let stray drains clear
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (results_due != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    initial begin
        int cols_raw, rows_raw, ncol, nrow, thr, nmaps, fill, drains, base;
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        func         = FUNC_CELL;
        cell_in      = 1'b0;
        burst_left   = 0;
        beats_taken  = 0;
        useful_beats = 0;
        cells_sent   = 0;
        drains_sent  = 0;
        maps_run     = 0;
        settings_run = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Drain with nothing pending, then the smallest map with clamped sizes
        push_beat(FUNC_DRAIN, 1'b1);
        apply_settings(0, 2, 0, 0);
        run_map(3, 3, 100, 5);
        settle();
        apply_settings(3, 3, 15, 1);
        run_map(3, 3, 50, 4);
        settle();

        base = useful_beats;
        while (useful_beats < base + RANDOM_ITEMS)
        begin
            cols_raw = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2)
                     : ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40)
                     : $urandom_range(3, 14);
            rows_raw = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2)
                     : $urandom_range(3, 10);
            thr = ($urandom_range(0, 9) < 7) ? $urandom_range(2, 6) : $urandom_range(0, 15);
            ncol = (cols_raw < 3) ? 3 : cols_raw;
            nrow = (rows_raw < 3) ? 3 : rows_raw;
            apply_settings(cols_raw, rows_raw, thr, $urandom_range(0, 1));
            nmaps = $urandom_range(1, 4);
            for (int m = 0; m < nmaps; m++) begin
                case ($urandom_range(0, 5))
                    0: fill = 0;
                    1: fill = 100;
                    2: fill = 15;
                    3: fill = 85;
                    default: fill = 50;
                endcase
                // cut a drain short only when another map follows
                if (m == nmaps - 1 || $urandom_range(0, 9) < 7)
                    drains = ncol + 1 + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
                else
                    drains = $urandom_range(0, ncol);
                run_map(ncol, nrow, fill, drains);
            end
            settle();
        end

        $display("covered %0d maps under %0d register settings: %0d cell beats, %0d drain beats",
                 maps_run, settings_run, cells_sent, drains_sent);
        $display("%0d smoothed cells compared, %0d mismatches", cells_checked, mismatches);
        if (mismatches == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

// ----- cave_automaton_smoothing_filter.f -----
rtl/cafs_pkg.sv
rtl/cafs_ram.sv
rtl/cafs_front.sv
rtl/cafs_queue.sv
rtl/cafs_back.sv
rtl/cave_automaton_smoothing_filter.sv
tb/cafs_checker.sv
tb/testbench.sv
